@@ sv/assert_macros.svh @@
// Assertion macros shared by the skinning unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a condition implies another on the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("%m: implication failed");
// Checks that a condition implies another on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("%m: next-cycle implication failed");
`endif

@@ sv/lbs_pkg.sv @@
// Package of types and constants for the linear blend skinning unit.
package lbs_pkg;
    localparam int unsigned BonesDefault      = 256;
    localparam int unsigned InfluencesDefault = 8;
    localparam int unsigned WordsPerBone      = 12;
    localparam logic [15:0] ThresholdReset    = 16'd33;
    localparam int unsigned QueueDepth        = 2;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_WEIGHT = 1'b1;

    typedef struct packed {
        logic               func;
        logic [7:0]         bone;
        logic [3:0]         word_index;
        logic signed [31:0] word_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
        logic [15:0]        weight;
        logic               last_weight;
    } t_item;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic               is_load;    // load item, written only if its word is in range
        logic               active;     // weight contributes
        logic               zero_mat;   // bone out of range: all-zero matrix
        logic               emit;       // last item of the vertex
        logic [7:0]         bone;
        logic [3:0]         word_index;
        logic signed [31:0] word_value;
        logic [2:0][31:0]   pos;        // three signed coordinates
        logic [2:0][31:0]   nrm;        // three signed coordinates
        logic [15:0]        weight;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROW, ST_ACC, ST_OUT, ST_HOLD
    } t_state;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
        logic [3:0]         weights_used;
    } t_result;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

@@ sv/lbs_front.sv @@
// Front part: accepts items, tracks vertex state and classifies items into commands.
module lbs_front import lbs_pkg::*; #(
    parameter int unsigned BONES      = BonesDefault,
    parameter int unsigned INFLUENCES = InfluencesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    input  logic [15:0] i_threshold,
    output logic        o_ready,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_ready
);
    logic       r_stopped, n_stopped;
    logic [4:0] r_count, n_count;
    logic       take;
    logic       act;

    assign o_ready     = i_cmd_ready;
    assign take        = i_valid & i_cmd_ready;
    assign o_cmd_valid = i_valid;

    always_comb begin
        act = (i_item.func == FUNC_WEIGHT) && !r_stopped
              && (r_count < 5'(INFLUENCES)) && (i_item.weight >= i_threshold);
        o_cmd.is_load    = (i_item.func == FUNC_LOAD);
        o_cmd.active     = act;
        o_cmd.zero_mat   = 32'(i_item.bone) >= BONES;
        o_cmd.emit       = (i_item.func == FUNC_WEIGHT) && i_item.last_weight;
        o_cmd.bone       = i_item.bone;
        o_cmd.word_index = i_item.word_index;
        o_cmd.word_value = i_item.word_value;
        o_cmd.pos[0]     = i_item.pos_x;
        o_cmd.pos[1]     = i_item.pos_y;
        o_cmd.pos[2]     = i_item.pos_z;
        o_cmd.nrm[0]     = i_item.nrm_x;
        o_cmd.nrm[1]     = i_item.nrm_y;
        o_cmd.nrm[2]     = i_item.nrm_z;
        o_cmd.weight     = i_item.weight;
        n_stopped = r_stopped;
        n_count   = r_count;
        if (i_item.func == FUNC_WEIGHT) begin
            if (!r_stopped && r_count < 5'(INFLUENCES)) begin
                if (i_item.weight < i_threshold) n_stopped = 1'b1;
                else n_count = r_count + 5'd1;
            end
            if (i_item.last_weight) begin
                n_stopped = 1'b0;
                n_count   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped <= 1'b0;
            r_count   <= '0;
        end else if (take) begin
            r_stopped <= n_stopped;
            r_count   <= n_count;
        end
    end
endmodule

@@ sv/lbs_queue.sv @@
// Short command queue between the front and back parts.
module lbs_queue import lbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_ready
);
    t_cmd       r_mem [QueueDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = r_cnt != 2'(QueueDepth);
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];
    assign wr      = i_valid & o_ready;
    assign rd      = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end
endmodule

@@ sv/lbs_back.sv @@
// Back part: palette memory, shared multipliers, accumulators and result register.
module lbs_back import lbs_pkg::*; #(
    parameter int unsigned BONES = BonesDefault
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_cmd    i_cmd,
    output logic    o_ready,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_pop
);
    // One row per memory word holds a whole bone: three rows of four words.
    logic [WordsPerBone*32-1:0] r_pal [BONES];
    logic [WordsPerBone*32-1:0] r_mat;
    localparam int unsigned BW = (BONES > 1) ? $clog2(BONES) : 1;

    t_state r_state, n_state;
    logic [1:0] r_row;
    logic signed [63:0] r_pa [3];
    logic signed [63:0] r_na [3];
    logic [3:0] r_used;
    logic signed [63:0] r_pp [3];
    logic signed [63:0] r_np [3];
    logic r_out_v;
    t_result r_out;
    logic [BW-1:0] idx;
    logic wr_word;
    logic signed [31:0] m [4];
    logic signed [65:0] sp, sn;

    assign idx     = BW'(i_cmd.bone);
    assign wr_word = i_valid && r_state == ST_IDLE && i_cmd.is_load && !i_cmd.zero_mat
                     && (i_cmd.word_index < 4'(WordsPerBone));

    // Read-modify-write of whole rows would need two ports; instead a load writes
    // one 32-bit lane of the row using a lane mask.
    always_ff @(posedge i_clk) begin
        if (wr_word)
            r_pal[idx][32*i_cmd.word_index +: 32] <= i_cmd.word_value;
        if (r_state == ST_IDLE) r_mat <= r_pal[idx];
    end

    always_comb begin
        for (int c = 0; c < 4; c++)
            m[c] = i_cmd.zero_mat ? 32'sd0 : $signed(r_mat[32*(4*r_row+c) +: 32]);
        sp = 66'(r_pp[0] >>> 16) + 66'(r_pp[1] >>> 16) + 66'(r_pp[2] >>> 16) + 66'(m[3]);
        sn = 66'(r_np[0] >>> 16) + 66'(r_np[1] >>> 16) + 66'(r_np[2] >>> 16);
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid && !i_cmd.is_load && !(r_out_v && i_cmd.emit)) n_state = ST_ROW;
            ST_ROW:  n_state = ST_ACC;
            ST_ACC:  n_state = (r_row == 2'd2) ? ST_OUT : ST_ROW;
            ST_OUT:  n_state = ST_IDLE;
            ST_HOLD: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE && i_valid && i_cmd.is_load)
                     || (r_state == ST_OUT);
    assign o_res_valid = r_out_v;
    assign o_res = r_out;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_pp[c] <= m[c] * $signed(i_cmd.pos[c]);
            r_np[c] <= m[c] * $signed(i_cmd.nrm[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_out_v <= 1'b0;
            r_used  <= '0;
            for (int r = 0; r < 3; r++) begin
                r_pa[r] <= '0;
                r_na[r] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_out_v && i_res_pop) r_out_v <= 1'b0;
            if (r_state == ST_ACC) begin
                if (i_cmd.active) begin
                    r_pa[r_row] <= r_pa[r_row] + $signed({1'b0, i_cmd.weight}) * sat32(sp);
                    r_na[r_row] <= r_na[r_row] + $signed({1'b0, i_cmd.weight}) * sat32(sn);
                end
                r_row <= (r_row == 2'd2) ? 2'd0 : r_row + 2'd1;
            end
            if (r_state == ST_OUT) begin
                if (i_cmd.active) r_used <= r_used + 4'd1;
                if (i_cmd.emit) begin
                    r_out_v <= 1'b1;
                    r_out.pos_x <= sat32(66'(r_pa[0] >>> 15));
                    r_out.pos_y <= sat32(66'(r_pa[1] >>> 15));
                    r_out.pos_z <= sat32(66'(r_pa[2] >>> 15));
                    r_out.nrm_x <= sat32(66'(r_na[0] >>> 15));
                    r_out.nrm_y <= sat32(66'(r_na[1] >>> 15));
                    r_out.nrm_z <= sat32(66'(r_na[2] >>> 15));
                    r_out.weights_used <= r_used + 4'(i_cmd.active);
                    r_used <= '0;
                    for (int r = 0; r < 3; r++) begin
                        r_pa[r] <= '0;
                        r_na[r] <= '0;
                    end
                end
            end
        end
    end
endmodule

@@ sv/linear_blend_skinning_unit.sv @@
// Linear blend skinning unit: the back part's finish step registers a final weight item's result.
// The back part takes no new item until a weight item is through: a palette read, a multiply and
// an accumulate step per matrix row on the three shared 32x32 multipliers per stream, and a finish.
// A load item is taken when idle; a final weight item waits while an earlier result is not taken.
// Reset (synchronous, active low) clears the vertex sums and counts and sets the threshold to
// 33; the palette is not cleared and reads of unwritten words are undefined.
module linear_blend_skinning_unit import lbs_pkg::*; #(
    parameter int unsigned BONES      = BonesDefault,
    parameter int unsigned INFLUENCES = InfluencesDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_func,
    input  logic [7:0]         i_bone,
    input  logic [3:0]         i_word_index,
    input  logic signed [31:0] i_word_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_nrm_x,
    input  logic signed [31:0] i_nrm_y,
    input  logic signed [31:0] i_nrm_z,
    input  logic [15:0]        i_weight,
    input  logic               i_last_weight,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [31:0] o_out_nrm_x,
    output logic signed [31:0] o_out_nrm_y,
    output logic signed [31:0] o_out_nrm_z,
    output logic [3:0]         o_weights_used
);
    `include "assert_macros.svh"

    logic [15:0] r_threshold;
    t_item   item;
    t_cmd    f_cmd, q_cmd;
    logic    f_valid, f_ready, q_ready, q_valid, b_ready, res_v;
    t_result res;

    // The user must write the threshold register only while the unit is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_threshold <= ThresholdReset;
        else if (i_cfg_we) r_threshold <= i_cfg_data;
    end

    assign item = '{i_func, i_bone, i_word_index, i_word_value, i_pos_x, i_pos_y, i_pos_z,
                    i_nrm_x, i_nrm_y, i_nrm_z, i_weight, i_last_weight};

    lbs_front #(.BONES(BONES), .INFLUENCES(INFLUENCES)) u_front (
        .i_clk, .i_rst_n, .i_valid(push), .i_item(item), .i_threshold(r_threshold),
        .o_ready(f_ready), .o_cmd_valid(f_valid), .o_cmd(f_cmd), .i_cmd_ready(q_ready)
    );

    lbs_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_cmd(f_cmd), .o_ready(q_ready),
        .o_valid(q_valid), .o_cmd(q_cmd), .i_ready(b_ready)
    );

    lbs_back #(.BONES(BONES)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_cmd(q_cmd), .o_ready(b_ready),
        .o_res_valid(res_v), .o_res(res), .i_res_pop(pop)
    );

    assign full           = !f_ready;
    assign empty          = !res_v;
    assign o_out_pos_x    = res.pos_x;
    assign o_out_pos_y    = res.pos_y;
    assign o_out_pos_z    = res.pos_z;
    assign o_out_nrm_x    = res.nrm_x;
    assign o_out_nrm_y    = res.nrm_y;
    assign o_out_nrm_z    = res.nrm_z;
    assign o_weights_used = res.weights_used;

    // A result waiting and not taken stays.
    `ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, !empty && !pop, !empty)
    // A full queue always offers a command to the back part.
    `ASSERT_IMPLIES(a_full_q, i_clk, i_rst_n, full, q_valid)
    // The count of used weights never exceeds the influence limit.
    `ASSERT_IMPLIES(a_used, i_clk, i_rst_n, !empty, 32'(o_weights_used) <= INFLUENCES)
endmodule
